FILE: design/clc_pkg.sv
// clc_pkg: constants, ramp table and types for the contact light controller
// no dependencies; imported by contact_light_controller_top
`timescale 1ns / 1ps

package clc_pkg;

	localparam int CONTACTS               = 4;
	localparam int SAMPLE_PERIOD_DEF      = 20;
	localparam int RAMP_STEPS_DEF         = 32;
	localparam int DEFAULT_STEP_DELAY_DEF = 20;
	localparam int MIN_STEP_DELAY         = 10;
	localparam int TABLE_DEPTH            = 32;

	localparam logic [3:0] ACTIVE_LEVELS_RST = 4'd3;
	localparam logic [7:0] STEP_DELAY_RST    = 8'd20;

	localparam logic [7:0] RAMP_TABLE [TABLE_DEPTH] = '{
		8'd0,   8'd1,   8'd2,   8'd3,   8'd5,   8'd8,   8'd12,  8'd16,
		8'd21,  8'd26,  8'd32,  8'd38,  8'd45,  8'd52,  8'd60,  8'd68,
		8'd76,  8'd85,  8'd95,  8'd105, 8'd115, 8'd125, 8'd136, 8'd148,
		8'd160, 8'd172, 8'd185, 8'd198, 8'd211, 8'd225, 8'd239, 8'd255
	};

	typedef enum logic [2:0] {
		CFG_ACTIVE_LEVELS,
		CFG_FUNCTIONS,
		CFG_DARK_ONLY_MASK,
		CFG_OFF_DELAY_0,
		CFG_OFF_DELAY_1,
		CFG_OFF_DELAY_2,
		CFG_OFF_DELAY_3,
		CFG_STEP_DELAY
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FN_SWITCH,
		FN_RAMP,
		FN_TOGGLE,
		FN_NONE
	} func_t;

	typedef enum logic [1:0] {
		RAMP_IDLE,
		RAMP_UP,
		RAMP_DOWN
	} ramp_mode_t;

	typedef struct packed {
		logic       moved;
		logic [7:0] duty;
	} step_t;

	typedef struct packed {
		logic       sw;
		logic [7:0] duty;
		ramp_mode_t mode;
		logic [7:0] ramp_cnt;
	} chan_t;

endpackage

FILE: design/contact_light_controller_top.sv
// contact_light_controller_top: contact sampling, switch/toggle/ramp actions, off delays
// depends on clc_pkg (ramp table, register indexes, channel types)
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  in       | in_valid / in_stall    | raw_levels, dark, brightness_cap
//  out      | out_valid / out_stall  | contact_states, changed_mask, switch_levels,
//           |                        | duty_0..duty_3, night_led
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// one beat per clock unless out_stall holds the output register; a beat is registered in the input register and
// its result is then registered into the output register, unless out_stall holds that register
// all contact state is updated when a beat moves from the input register to the output register
// arst_n clears control and contact state; configuration registers return to their reset values
// out_stall holds the output register; in_stall rises only when both stages are full
`timescale 1ns / 1ps

module contact_light_controller_top import clc_pkg::*; #(
	parameter int SAMPLE_PERIOD      = SAMPLE_PERIOD_DEF,
	parameter int RAMP_STEPS         = RAMP_STEPS_DEF,
	parameter int DEFAULT_STEP_DELAY = DEFAULT_STEP_DELAY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  raw_levels,
	input  logic        dark,
	input  logic [7:0]  brightness_cap,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  contact_states,
	output logic [3:0]  changed_mask,
	output logic [3:0]  switch_levels,
	output logic [7:0]  duty_0,
	output logic [7:0]  duty_1,
	output logic [7:0]  duty_2,
	output logic [7:0]  duty_3,
	output logic        night_led,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int SC_W = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;
	localparam logic [SC_W-1:0] SC_RELOAD = SC_W'(SAMPLE_PERIOD - 1);

	// configuration registers
	logic [3:0]  active_levels_q;
	logic [7:0]  functions_q;
	logic [3:0]  dark_only_mask_q;
	logic [15:0] off_delay_q [CONTACTS];
	logic [7:0]  step_delay_q;

	// input stage
	logic        valid_s1;
	logic [3:0]  raw_levels_s1;
	logic        dark_s1;
	logic [7:0]  cap_s1;

	// output stage
	logic        valid_s2;
	logic [3:0]  contact_states_s2;
	logic [3:0]  changed_mask_s2;
	logic [3:0]  switch_levels_s2;
	logic [7:0]  duty_s2 [CONTACTS];
	logic        night_led_s2;

	// contact state
	logic [CONTACTS-1:0] cstate_q, cstate_d;
	logic [CONTACTS-1:0] pend_q, pend_d;
	logic [15:0]         offcnt_q [CONTACTS];
	logic [15:0]         offcnt_d [CONTACTS];
	chan_t               chan_q [CONTACTS];
	chan_t               chan_d [CONTACTS];
	logic [SC_W-1:0]     sample_cnt_q, sample_cnt_d;

	logic [CONTACTS-1:0] changed;
	logic [CONTACTS-1:0] sw_vec;
	logic [7:0]          eff_delay;
	logic                out_adv;
	logic                fire;

	function automatic step_t step_up(input logic [7:0] d, input logic [7:0] cap);
		step_t r;
		r = '0;
		for (int k = RAMP_STEPS - 1; k >= 0; k--) begin
			if (RAMP_TABLE[k] > d) begin
				r.moved = 1'b1;
				r.duty  = (RAMP_TABLE[k] > cap) ? cap : RAMP_TABLE[k];
			end
		end
		return r;
	endfunction

	function automatic step_t step_down(input logic [7:0] d);
		step_t r;
		r = '0;
		for (int k = 1; k < RAMP_STEPS; k++) begin
			if (RAMP_TABLE[k] <= d) begin
				r.moved = 1'b1;
				r.duty  = RAMP_TABLE[k-1];
			end
		end
		return r;
	endfunction

	function automatic chan_t do_action(input func_t fn, input logic on, input logic [7:0] cap,
			input logic [7:0] dly, input chan_t c);
		chan_t r;
		step_t s;
		r = c;
		case (fn)
			FN_SWITCH: r.sw = on;
			FN_TOGGLE: r.sw = ~c.sw;
			FN_RAMP: begin
				s = on ? step_up(c.duty, cap) : step_down(c.duty);
				if (s.moved) begin
					r.duty     = s.duty;
					r.mode     = on ? RAMP_UP : RAMP_DOWN;
					r.ramp_cnt = dly;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic chan_t ramp_tick(input logic [7:0] cap, input logic [7:0] dly,
			input chan_t c);
		chan_t r;
		step_t s;
		r = c;
		if (c.mode != RAMP_IDLE) begin
			r.ramp_cnt = c.ramp_cnt - 8'd1;
			if (r.ramp_cnt == 8'd0) begin
				s = (c.mode == RAMP_UP) ? step_up(c.duty, cap) : step_down(c.duty);
				if (s.moved) begin
					r.duty     = s.duty;
					r.ramp_cnt = dly;
				end else begin
					r.mode = RAMP_IDLE;
				end
			end
		end
		return r;
	endfunction

	assign out_adv  = ~valid_s2 | ~out_stall;
	assign fire     = valid_s1 & out_adv;
	assign in_stall = valid_s1 & ~out_adv;

	assign eff_delay = (step_delay_q < 8'(MIN_STEP_DELAY)) ? 8'(DEFAULT_STEP_DELAY)
		: step_delay_q;

	always_comb begin
		logic st;
		func_t fn;
		sample_cnt_d = (sample_cnt_q == '0) ? SC_RELOAD : sample_cnt_q - SC_W'(1);
		cstate_d = cstate_q;
		pend_d   = pend_q;
		changed  = '0;
		for (int i = 0; i < CONTACTS; i++) begin
			st = 1'b0;
			fn = func_t'(functions_q[2*i +: 2]);
			chan_d[i]   = chan_q[i];
			offcnt_d[i] = offcnt_q[i];
			// pending off delay
			if (pend_q[i]) begin
				offcnt_d[i] = offcnt_q[i] - 16'd1;
				if (offcnt_d[i] == 16'd0) begin
					pend_d[i] = 1'b0;
					chan_d[i] = do_action(fn, 1'b0, cap_s1, eff_delay, chan_d[i]);
				end
			end
			// running ramp
			chan_d[i] = ramp_tick(cap_s1, eff_delay, chan_d[i]);
			// sampling
			if (sample_cnt_q == '0) begin
				st = active_levels_q[i] ? raw_levels_s1[i] : ~raw_levels_s1[i];
				if (st != cstate_q[i]) begin
					changed[i] = 1'b1;
					if (st) begin
						if (!dark_only_mask_q[i] || dark_s1)
							chan_d[i] = do_action(fn, 1'b1, cap_s1, eff_delay, chan_d[i]);
					end else if (off_delay_q[i] == 16'd0) begin
						chan_d[i] = do_action(fn, 1'b0, cap_s1, eff_delay, chan_d[i]);
					end else begin
						offcnt_d[i] = off_delay_q[i];
						pend_d[i]   = 1'b1;
					end
					cstate_d[i] = st;
				end
			end
			sw_vec[i] = chan_d[i].sw;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_levels_q  <= ACTIVE_LEVELS_RST;
			functions_q      <= '0;
			dark_only_mask_q <= '0;
			step_delay_q     <= STEP_DELAY_RST;
			for (int i = 0; i < CONTACTS; i++)
				off_delay_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ACTIVE_LEVELS:  active_levels_q  <= cfg_data[3:0];
				CFG_FUNCTIONS:      functions_q      <= cfg_data[7:0];
				CFG_DARK_ONLY_MASK: dark_only_mask_q <= cfg_data[3:0];
				CFG_OFF_DELAY_0:    off_delay_q[0]   <= cfg_data;
				CFG_OFF_DELAY_1:    off_delay_q[1]   <= cfg_data;
				CFG_OFF_DELAY_2:    off_delay_q[2]   <= cfg_data;
				CFG_OFF_DELAY_3:    off_delay_q[3]   <= cfg_data;
				CFG_STEP_DELAY:     step_delay_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			raw_levels_s1 <= raw_levels;
			dark_s1       <= dark;
			cap_s1        <= brightness_cap;
		end
	end

	// contact state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cstate_q     <= '0;
			pend_q       <= '0;
			sample_cnt_q <= '0;
			for (int i = 0; i < CONTACTS; i++) begin
				offcnt_q[i] <= '0;
				chan_q[i]   <= '0;
			end
		end else if (fire) begin
			cstate_q     <= cstate_d;
			pend_q       <= pend_d;
			sample_cnt_q <= sample_cnt_d;
			for (int i = 0; i < CONTACTS; i++) begin
				offcnt_q[i] <= offcnt_d[i];
				chan_q[i]   <= chan_d[i];
			end
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			contact_states_s2 <= cstate_d;
			changed_mask_s2   <= changed;
			switch_levels_s2  <= sw_vec;
			night_led_s2      <= dark_s1;
			for (int i = 0; i < CONTACTS; i++)
				duty_s2[i] <= chan_d[i].duty;
		end
	end

	assign out_valid      = valid_s2;
	assign contact_states = contact_states_s2;
	assign changed_mask   = changed_mask_s2;
	assign switch_levels  = switch_levels_s2;
	assign duty_0         = duty_s2[0];
	assign duty_1         = duty_s2[1];
	assign duty_2         = duty_s2[2];
	assign duty_3         = duty_s2[3];
	assign night_led      = night_led_s2;

endmodule

FILE: verif/contact_light_controller_tb.sv
// testbench for contact_light_controller_top: a self-checking tick predictor fed by random contact traffic
// depends on clc_pkg and contact_light_controller_top from the design folder
`timescale 1ns / 1ps

module testbench;
	import clc_pkg::*;

	localparam int LIMIT = 600000;
	localparam int DRAIN = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  raw_levels;
	logic        dark;
	logic [7:0]  brightness_cap;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  contact_states;
	logic [3:0]  changed_mask;
	logic [3:0]  switch_levels;
	logic [7:0]  duty_0;
	logic [7:0]  duty_1;
	logic [7:0]  duty_2;
	logic [7:0]  duty_3;
	logic        night_led;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	typedef struct packed {
		logic [3:0] states;
		logic [3:0] changed;
		logic [3:0] sw;
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
		logic [7:0] d3;
		logic       night;
	} tick_out_t;

	class light_board;
		logic [3:0]  act_lv;
		logic [7:0]  fn_bits;
		logic [3:0]  dark_mask;
		logic [15:0] off_dly [4];
		logic [7:0]  step_dly;
		bit          lit [4];
		bit          sw_lv [4];
		logic [7:0]  duty [4];
		logic [15:0] off_cnt [4];
		bit          off_pend [4];
		ramp_mode_t  mode [4];
		logic [7:0]  ramp_cnt [4];
		int          sample_cnt;
		tick_out_t   outputs_due [$];
		int          errors;

		function new();
			act_lv = ACTIVE_LEVELS_RST;
			fn_bits = '0;
			dark_mask = '0;
			step_dly = STEP_DELAY_RST;
			for (int i = 0; i < CONTACTS; i++) begin
				off_dly[i] = '0;
				lit[i] = 1'b0;
				sw_lv[i] = 1'b0;
				duty[i] = '0;
				off_cnt[i] = '0;
				off_pend[i] = 1'b0;
				mode[i] = RAMP_IDLE;
				ramp_cnt[i] = '0;
			end
			sample_cnt = 0;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] val);
			case (idx)
				CFG_ACTIVE_LEVELS: act_lv = val[3:0];
				CFG_FUNCTIONS: fn_bits = val[7:0];
				CFG_DARK_ONLY_MASK: dark_mask = val[3:0];
				CFG_OFF_DELAY_0: off_dly[0] = val;
				CFG_OFF_DELAY_1: off_dly[1] = val;
				CFG_OFF_DELAY_2: off_dly[2] = val;
				CFG_OFF_DELAY_3: off_dly[3] = val;
				CFG_STEP_DELAY: step_dly = val[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return outputs_due.size();
		endfunction

		function logic [7:0] step_len();
			return (step_dly < MIN_STEP_DELAY) ? 8'(DEFAULT_STEP_DELAY_DEF) : step_dly;
		endfunction

		function bit climb(int i, logic [7:0] cap);
			for (int k = 0; k < RAMP_STEPS_DEF; k++) begin
				if (RAMP_TABLE[k] > duty[i]) begin
					duty[i] = (RAMP_TABLE[k] > cap) ? cap : RAMP_TABLE[k];
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function bit sink(int i);
			int k;
			k = 0;
			for (int j = 0; j < RAMP_STEPS_DEF; j++)
				if (RAMP_TABLE[j] <= duty[i])
					k = j;
			if (k == 0)
				return 1'b0;
			duty[i] = RAMP_TABLE[k - 1];
			return 1'b1;
		endfunction

		function void fire(int i, bit activate, logic [7:0] cap);
			bit moved;
			case (func_t'(fn_bits[2*i +: 2]))
				FN_SWITCH: sw_lv[i] = activate;
				FN_TOGGLE: sw_lv[i] = !sw_lv[i];
				FN_RAMP: begin
					moved = activate ? climb(i, cap) : sink(i);
					if (moved) begin
						mode[i] = activate ? RAMP_UP : RAMP_DOWN;
						ramp_cnt[i] = step_len();
					end
				end
				default: ;
			endcase
		endfunction

		// one millisecond tick: off delays, then ramps, then sampling
		function void take_tick(logic [3:0] raw, logic dk, logic [7:0] cap);
			tick_out_t  r;
			logic [3:0] chg;
			bit         st;
			bit         moved;
			chg = '0;
			for (int i = 0; i < CONTACTS; i++) begin
				if (off_pend[i]) begin
					off_cnt[i] = off_cnt[i] - 16'd1;
					if (off_cnt[i] == 16'd0) begin
						off_pend[i] = 1'b0;
						fire(i, 1'b0, cap);
					end
				end
			end
			for (int i = 0; i < CONTACTS; i++) begin
				if (mode[i] != RAMP_IDLE) begin
					ramp_cnt[i] = ramp_cnt[i] - 8'd1;
					if (ramp_cnt[i] == 8'd0) begin
						moved = (mode[i] == RAMP_UP) ? climb(i, cap) : sink(i);
						if (moved)
							ramp_cnt[i] = step_len();
						else
							mode[i] = RAMP_IDLE;
					end
				end
			end
			if (sample_cnt == 0) begin
				sample_cnt = SAMPLE_PERIOD_DEF - 1;
				for (int i = 0; i < CONTACTS; i++) begin
					st = act_lv[i] ? raw[i] : !raw[i];
					if (st != lit[i]) begin
						chg[i] = 1'b1;
						if (st) begin
							if (!dark_mask[i] || dk)
								fire(i, 1'b1, cap);
						end else if (off_dly[i] == 16'd0) begin
							fire(i, 1'b0, cap);
						end else begin
							off_cnt[i] = off_dly[i];
							off_pend[i] = 1'b1;
						end
						lit[i] = st;
					end
				end
			end else begin
				sample_cnt--;
			end
			r.states = {lit[3], lit[2], lit[1], lit[0]};
			r.changed = chg;
			r.sw = {sw_lv[3], sw_lv[2], sw_lv[1], sw_lv[0]};
			r.d0 = duty[0];
			r.d1 = duty[1];
			r.d2 = duty[2];
			r.d3 = duty[3];
			r.night = dk;
			outputs_due.push_back(r);
		endfunction

		function void compare_field(string nm, logic [7:0] e, logic [7:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, nm, e, a);
			end
		endfunction

		function void match_output(tick_out_t got);
			tick_out_t e;
			if (outputs_due.size() == 0) begin
				errors++;
				$display("%0t: output beat with none due, expected nothing got %h", $time, got);
				return;
			end
			e = outputs_due.pop_front();
			compare_field("contact_states", e.states, got.states);
			compare_field("changed_mask", e.changed, got.changed);
			compare_field("switch_levels", e.sw, got.sw);
			compare_field("duty_0", e.d0, got.d0);
			compare_field("duty_1", e.d1, got.d1);
			compare_field("duty_2", e.d2, got.d2);
			compare_field("duty_3", e.d3, got.d3);
			compare_field("night_led", e.night, got.night);
		endfunction
	endclass

	light_board board;
	tick_out_t  beat_out;
	int         cycles = 0;
	int         rx_hold_req = 0;
	bit         rx_quiet = 1'b0;
	bit         tx_quiet = 1'b0;
	logic [3:0] stim_levels;
	logic       stim_dark;
	logic [7:0] stim_cap;

	contact_light_controller_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.raw_levels     (raw_levels),
		.dark           (dark),
		.brightness_cap (brightness_cap),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.contact_states (contact_states),
		.changed_mask   (changed_mask),
		.switch_levels  (switch_levels),
		.duty_0         (duty_0),
		.duty_1         (duty_1),
		.duty_2         (duty_2),
		.duty_3         (duty_3),
		.night_led      (night_led),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign beat_out = {contact_states, changed_mask, switch_levels,
		duty_0, duty_1, duty_2, duty_3, night_led};

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.take_tick(raw_levels, dark, brightness_cap);
			if (out_valid && !out_stall)
				board.match_output(beat_out);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int tx_gap();
		int r;
		r = $urandom_range(99, 0);
		if (tx_quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	function automatic int rx_pause();
		int r;
		r = $urandom_range(99, 0);
		if (r < 22)
			return $urandom_range(3, 1);
		if (r < 25)
			return $urandom_range(40, 8);
		return 0;
	endfunction

	// sink side: random stalls plus a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				stall_left = rx_hold_req;
				rx_hold_req = 0;
			end else if (stall_left == 0 && !rx_quiet) begin
				stall_left = rx_pause();
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_tick(logic [3:0] raw, logic dk, logic [7:0] cap);
		int gap;
		in_valid <= 1'b1;
		raw_levels <= raw;
		dark <= dk;
		brightness_cap <= cap;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = tx_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic apply_cfg(logic [3:0] al, logic [7:0] fn, logic [3:0] dm,
		logic [63:0] od, logic [7:0] sd);
		logic [15:0] vals [8];
		vals[CFG_ACTIVE_LEVELS] = {12'd0, al};
		vals[CFG_FUNCTIONS] = {8'd0, fn};
		vals[CFG_DARK_ONLY_MASK] = {12'd0, dm};
		vals[CFG_OFF_DELAY_0] = od[15:0];
		vals[CFG_OFF_DELAY_1] = od[31:16];
		vals[CFG_OFF_DELAY_2] = od[47:32];
		vals[CFG_OFF_DELAY_3] = od[63:48];
		vals[CFG_STEP_DELAY] = {8'd0, sd};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			board.set_reg(cfg_idx_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_cfg();
		logic [63:0] od;
		logic [7:0]  sd;
		int          r;
		for (int i = 0; i < CONTACTS; i++) begin
			r = $urandom_range(99, 0);
			if (r < 35)
				od[16*i +: 16] = 16'd0;
			else if (r < 90)
				od[16*i +: 16] = 16'($urandom_range(60, 1));
			else if (r < 97)
				od[16*i +: 16] = 16'($urandom_range(400, 61));
			else
				od[16*i +: 16] = 16'hFFFF;
		end
		r = $urandom_range(99, 0);
		if (r < 20)
			sd = 8'($urandom_range(9, 0));
		else if (r < 90)
			sd = 8'($urandom_range(30, 10));
		else
			sd = 8'($urandom_range(255, 200));
		apply_cfg(4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)),
			4'($urandom_range(15, 0)), od, sd);
	endtask

	// levels hold for a while so that several samples see the same state
	task automatic run_phase(int n, int flip_div);
		int r;
		for (int k = 0; k < n; k++) begin
			for (int b = 0; b < 4; b++)
				if ($urandom_range(flip_div - 1, 0) == 0)
					stim_levels[b] = !stim_levels[b];
			if ($urandom_range(59, 0) == 0)
				stim_dark = !stim_dark;
			if ($urandom_range(39, 0) == 0) begin
				r = $urandom_range(9, 0);
				if (r < 5)
					stim_cap = 8'd255;
				else if (r < 8)
					stim_cap = 8'($urandom_range(255, 0));
				else
					stim_cap = 8'($urandom_range(20, 0));
			end
			if ($urandom_range(99, 0) == 0)
				tx_quiet = !tx_quiet;
			if ($urandom_range(149, 0) == 0)
				rx_quiet = !rx_quiet;
			send_tick(stim_levels, stim_dark, stim_cap);
		end
		tx_quiet = 1'b0;
	endtask

	function automatic int pick_flip();
		case ($urandom_range(2, 0))
			0: return 25;
			1: return 60;
			default: return 250;
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_levels = '0;
		dark = 1'b0;
		brightness_cap = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ACTIVE_LEVELS;
		cfg_data = '0;
		stim_levels = '0;
		stim_dark = 1'b0;
		stim_cap = 8'd255;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one contact per function, extremes of level, dark and cap
		apply_cfg(4'hF, {FN_NONE, FN_TOGGLE, FN_RAMP, FN_SWITCH}, 4'h2,
			{16'd1, 16'd0, 16'd3, 16'd0}, 8'd0);
		for (int k = 0; k < 24; k++)
			send_tick((k == 20 || k == 21) ? 4'h0 : 4'hF, (k < 20) ? k[0] : 1'b0,
				k[1] ? 8'd0 : 8'd255);
		settle();

		apply_cfg(4'hF, {FN_RAMP, FN_RAMP, FN_RAMP, FN_RAMP}, 4'h0, 64'd0, 8'd10);
		run_phase(125, 250);
		settle();
		apply_cfg(4'h0, {FN_TOGGLE, FN_TOGGLE, FN_TOGGLE, FN_TOGGLE}, 4'hF,
			{16'd1, 16'd2, 16'd3, 16'hFFFF}, 8'd255);
		run_phase(125, 30);
		settle();
		apply_cfg(4'hA, {FN_NONE, FN_NONE, FN_NONE, FN_NONE}, 4'h0,
			{16'd5, 16'd5, 16'd5, 16'd5}, 8'd9);
		run_phase(125, 30);
		settle();
		apply_cfg(4'h5, {FN_SWITCH, FN_SWITCH, FN_SWITCH, FN_SWITCH}, 4'h3,
			{16'hFFFF, 16'd0, 16'd40, 16'd0}, 8'd0);
		run_phase(125, 60);

		// long sink hold-off while ticks keep coming
		rx_hold_req = 70;
		tx_quiet = 1'b1;
		run_phase(30, 25);
		settle();

		for (int p = 0; p < 7; p++) begin
			random_cfg();
			run_phase(125, pick_flip());
			settle();
		end

		if (board.errors == 0 && board.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
